[rtl/core/aes128_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 package
// S-box, round constants and round helper functions shared by the core.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned BlockW   = 128;
  localparam int unsigned NumRound = 10;

  // Configuration register indexes.
  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  typedef logic [7:0] byte_t;
  typedef logic [BlockW-1:0] block_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RCON [NumRound] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block; byte 0 is the most significant.
  function automatic byte_t get_byte(block_t b, int unsigned i);
    get_byte = b[BlockW-1-8*i -: 8];
  endfunction

  // Multiply by x in GF(2^8).
  function automatic byte_t xtime(byte_t x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes followed by ShiftRows.
  function automatic block_t sub_shift(block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
      end
    end
    sub_shift = t;
  endfunction

  // MixColumns on all four columns.
  function automatic block_t mix_cols(block_t s);
    block_t t;
    byte_t a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[BlockW-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[BlockW-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[BlockW-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

  // One step of the key expansion.
  function automatic block_t next_key(block_t k, byte_t rc);
    logic [31:0] w0, w1, w2, w3, tmp;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tmp;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

[rtl/core/aes128_block_encrypt_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encryption core
// Fully unrolled eleven-stage round pipeline with on-the-fly key expansion.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_index_i, cfg_data_i
// in        in         in_valid/in_ready    plain_high_i, plain_low_i
// out       out        out_valid/out_ready  cipher_high_o, cipher_low_o
//
// One block enters per cycle while the pipeline advances; each passes through the
// initial key-add stage and then one register stage per round of the chain.
// The round key travels alongside each block, so key writes only affect
// blocks accepted afterwards. The whole pipeline advances whenever its last
// stage is empty or the result is taken; a stall freezes every stage.
// Reset clears the valid bits and the key registers to zero.
module aes128_block_encrypt_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic                    cfg_index_i,
  input  wire logic [63:0]             cfg_data_i,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire logic [63:0]             plain_high_i,
  input  wire logic [63:0]             plain_low_i,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [63:0]             cipher_high_o,
  output      logic [63:0]             cipher_low_o
);
  import aes128_pkg::*;

  localparam int unsigned NumStage = NumRound + 1;

  logic [127:0] key_q;
  logic         valid_q [NumStage];
  block_t       state_q [NumStage];
  block_t       rkey_q  [NumStage];
  logic         advance;

  assign advance   = !valid_q[NumStage-1] || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        RegKeyHigh: key_q[127:64] <= cfg_data_i;
        RegKeyLow:  key_q[63:0]   <= cfg_data_i;
        default:    key_q         <= key_q;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStage; i++) valid_q[i] <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= in_valid;
      for (int i = 1; i < NumStage; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  // Stage 0 adds the cipher key; stages 1..10 each run one round.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      state_q[0] <= {plain_high_i, plain_low_i} ^ key_q;
      rkey_q[0]  <= key_q;
      for (int i = 1; i < NumStage; i++) begin
        rkey_q[i] <= next_key(rkey_q[i-1], RCON[i-1]);
        if (i == NumStage-1) begin
          state_q[i] <= sub_shift(state_q[i-1]) ^ next_key(rkey_q[i-1], RCON[i-1]);
        end else begin
          state_q[i] <= mix_cols(sub_shift(state_q[i-1]))
                        ^ next_key(rkey_q[i-1], RCON[i-1]);
        end
      end
    end
  end

  assign out_valid     = valid_q[NumStage-1];
  assign cipher_high_o = state_q[NumStage-1][127:64];
  assign cipher_low_o  = state_q[NumStage-1][63:0];

endmodule
`default_nettype wire

[rtl/core/aes128_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 port checker
// Watches the top-level ports for handshake and flow-control properties.
// ----------------------------------------------------------------------------
module aes128_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] cipher_high_o,
  input wire logic [63:0] cipher_low_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(cipher_high_o) && $stable(cipher_low_o))
    else $error("stalled result changed");

  // The input side only stalls while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // With the output empty, input is always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

  // A request that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("request withdrawn before acceptance");

endmodule

bind aes128_block_encrypt_top aes128_checker u_aes128_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
  .cipher_high_o, .cipher_low_o
);
`default_nettype wire

[dv/aes128_block_encrypt_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Drives plaintext requests under several keys, predicts each ciphertext with
// a behavioral AES-128 encryptor and compares every result in order, with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top_tb;
  import aes128_pkg::*;

  localparam int unsigned PipeDepth  = 11;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_blk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index_i = 1'b0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] plain_high_i = '0;
  logic [63:0] plain_low_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;

  // Key as the predictor sees it.
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;

  cipher_blk_t pending_ciphers[$];
  int          err_cnt = 0;
  bit          idle_on = 1'b1;
  bit          long_stall = 1'b0;
  int          hold_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  aes128_block_encrypt_top DUT (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .in_valid, .in_ready, .plain_high_i, .plain_low_i,
    .out_valid, .out_ready, .cipher_high_o, .cipher_low_o
  );

  // Behavioral S-box: multiplicative inverse followed by the affine map.
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] sbox_of(logic [7:0] x);
    logic [7:0] inv, y;
    inv = '0;
    for (int c = 1; c < 256; c++) begin
      if (gf_mul(x, c[7:0]) == 8'h01) inv = c[7:0];
    end
    y = 8'h63;
    for (int i = 0; i < 8; i++) begin
      y[i] = y[i] ^ inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8];
    end
    return y;
  endfunction

  logic [7:0] sbox_lut [256];
  initial begin
    for (int i = 0; i < 256; i++) sbox_lut[i] = sbox_of(i[7:0]);
  end

  // Full AES-128 encryption on byte arrays, byte 0 first.
  function automatic cipher_blk_t encrypt_block(logic [63:0] ph, logic [63:0] pl,
                                                logic [63:0] kh, logic [63:0] kl);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] rc, a0, a1, a2, a3, al;
    cipher_blk_t res;
    for (int i = 0; i < 8; i++) begin
      st[i] = ph[63-8*i -: 8];
      st[8+i] = pl[63-8*i -: 8];
      rk[i] = kh[63-8*i -: 8];
      rk[8+i] = kl[63-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    rc = 8'h01;
    for (int rnd = 0; rnd < 10; rnd++) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) tmp[4*c+r] = sbox_lut[st[4*((c+r)%4)+r]];
      end
      st = tmp;
      if (rnd < 9) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ gf_mul(a0 ^ a1, 8'h02);
          st[4*c+1] = a1 ^ al ^ gf_mul(a1 ^ a2, 8'h02);
          st[4*c+2] = a2 ^ al ^ gf_mul(a2 ^ a3, 8'h02);
          st[4*c+3] = a3 ^ al ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end
      // Next round key, round constant doubling in the field.
      rk[0] ^= sbox_lut[rk[13]] ^ rc;
      rk[1] ^= sbox_lut[rk[14]];
      rk[2] ^= sbox_lut[rk[15]];
      rk[3] ^= sbox_lut[rk[12]];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rc = gf_mul(rc, 8'h02);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = st[i];
      res.lo[63-8*i -: 8] = st[8+i];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random idle bursts, or none at all; the request is dropped while idle.
  task automatic idle_gap();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Send one plaintext request and record its expected ciphertext.
  // Valid stays high after acceptance so requests can follow back to back.
  task automatic send_block(logic [63:0] ph, logic [63:0] pl);
    idle_gap();
    in_valid     <= 1'b1;
    plain_high_i <= ph;
    plain_low_i  <= pl;
    do @(posedge clk_i); while (!in_ready);
    pending_ciphers.push_back(encrypt_block(ph, pl, key_hi_q, key_lo_q));
  endtask

  // Write one key register; the caller drops cfg_valid after the last write.
  task automatic write_reg(logic idx, logic [63:0] val);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == RegKeyHigh) key_hi_q = val;
    else key_lo_q = val;
  endtask

  // Wait until the pipeline has drained before touching the key.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_ciphers.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic set_key(logic [63:0] kh, logic [63:0] kl);
    drain();
    write_reg(RegKeyHigh, kh);
    write_reg(RegKeyLow, kl);
    cfg_valid <= 1'b0;
  endtask

  // Zero key straight after reset, plus field extremes and single set bits at either end.
  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h1);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
  endtask

  // Standard test key, extreme keys and single-register updates.
  task automatic test_directed_keys();
    set_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    set_key(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c);
    send_block(64'h3243_f6a8_885a_308d, 64'h3131_98a2_e037_0734);
    set_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    drain();
    write_reg(RegKeyLow, '0);
    cfg_valid <= 1'b0;
    send_block('1, '0);
    drain();
    write_reg(RegKeyHigh, '0);
    cfg_valid <= 1'b0;
    send_block('0, '1);
    send_block(64'h00ff_00ff_0000_ff00, 64'h0000_0000_ff00_00ff);
  endtask

  // Random blocks under a few random keys.
  task automatic test_random_stream(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) set_key(rand64(), rand64());
      send_block(rand64(), rand64());
    end
  endtask

  // Receiver holds off while the sender keeps pushing, filling the pipe.
  task automatic test_backpressure();
    set_key(rand64(), rand64());
    long_stall = 1'b1;
    for (int i = 0; i < 40; i++) send_block(rand64(), rand64());
  endtask

  // Output side: random idle bursts, and one long counted stall.
  always @(posedge clk_i) begin
    if (long_stall) begin
      out_ready   <= 1'b0;
      hold_cycles <= 59;
      long_stall  <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= $urandom_range(0, 17);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expected ciphertext.
  always @(posedge clk_i) begin
    cipher_blk_t exp_c;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_ciphers.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, cipher_high_o, cipher_low_o);
        err_cnt++;
      end else begin
        exp_c = pending_ciphers.pop_front();
        if (cipher_high_o !== exp_c.hi) begin
          $display("%0t: cipher_high expected %h actual %h", $time, exp_c.hi,
                   cipher_high_o);
          err_cnt++;
        end
        if (cipher_low_o !== exp_c.lo) begin
          $display("%0t: cipher_low expected %h actual %h", $time, exp_c.lo,
                   cipher_low_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake on the input, output or configuration channel.
  int unsigned quiet_cnt = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt > StallLimit) begin
      $display("** aes128_block_encrypt_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_key();
    test_directed_keys();
    test_backpressure();
    test_random_stream(900);
    idle_on = 1'b0;
    test_random_stream(200);
    drain();
    if (err_cnt == 0) begin
      $display("** aes128_block_encrypt_top: PASSED **");
    end else begin
      $display("** aes128_block_encrypt_top: FAILED **");
    end
    $finish;
  end

endmodule
